@@ design/tfm_pkg.sv @@
// ----------------------------------------------------------------------------
// tfm_pkg
// Shared types and constants of the touch raw-to-logical transform.
// ----------------------------------------------------------------------------
package tfm_pkg;

  // Coordinate and raw sample widths
  localparam int COORD_BITS = 12;
  localparam int RAW_W      = 16;
  localparam int NUM_W      = RAW_W + COORD_BITS;

  // Divider layout: restoring steps per pipeline stage
  localparam int DIV_SPS    = 3;
  localparam int DIV_STAGES = (COORD_BITS + DIV_SPS - 1) / DIV_SPS;

  // Accept-to-strobe latency: front stage, multiply, divider, output
  localparam int LAT = DIV_STAGES + 3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FLAG_W     = 3;
  localparam int ORIENT_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_MIN_X    = 3'd0,
    CFG_RAW_MAX_X    = 3'd1,
    CFG_RAW_MIN_Y    = 3'd2,
    CFG_RAW_MAX_Y    = 3'd3,
    CFG_AXIS_FLAGS   = 3'd4,
    CFG_PANEL_WIDTH  = 3'd5,
    CFG_PANEL_HEIGHT = 3'd6,
    CFG_ORIENTATION  = 3'd7
  } cfg_idx_t;

  typedef enum logic [ORIENT_W-1:0] {
    ORI_PORTRAIT     = 2'd0,
    ORI_LANDSCAPE_CW = 2'd1,
    ORI_PORTRAIT_INV = 2'd2,
    ORI_LANDSCAPE_CCW = 2'd3
  } orient_t;

  // Axis flag bit positions
  localparam int FLAG_SWAP     = 0;
  localparam int FLAG_MIRROR_X = 1;
  localparam int FLAG_MIRROR_Y = 2;

  // Control carried alongside each item in the pipeline
  typedef struct packed {
    logic vld;
    logic ok;
  } ctl_t;

endpackage

@@ design/tfm_div.sv @@
// ----------------------------------------------------------------------------
// tfm_div
// Pipelined restoring divider for one axis: NUM_W-bit numerator by a
// RAW_W-bit divisor, COORD_BITS-bit quotient, DIV_SPS steps per stage.
// ----------------------------------------------------------------------------
module tfm_div
  import tfm_pkg::*;
(
  input  logic                  clk,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [RAW_W-1:0]      den_i,
  output logic [COORD_BITS-1:0] quot_o
);

  // Per-stage remainder, numerator/quotient shift word and divisor
  logic [RAW_W-1:0]      rem_r   [DIV_STAGES];
  logic [COORD_BITS-1:0] low_r   [DIV_STAGES];
  logic [RAW_W-1:0]      den_r   [DIV_STAGES];
  logic [RAW_W-1:0]      rem_nxt [DIV_STAGES];
  logic [COORD_BITS-1:0] low_nxt [DIV_STAGES];
  logic [RAW_W-1:0]      rem_in  [DIV_STAGES];
  logic [COORD_BITS-1:0] low_in  [DIV_STAGES];
  logic [RAW_W-1:0]      den_in  [DIV_STAGES];

  // Stage inputs: first stage from the ports, the rest from the previous stage
  always_comb begin
    rem_in[0] = num_i[NUM_W-1 -: RAW_W];
    low_in[0] = num_i[COORD_BITS-1:0];
    den_in[0] = den_i;
    for (int s = 1; s < DIV_STAGES; s++) begin
      rem_in[s] = rem_r[s-1];
      low_in[s] = low_r[s-1];
      den_in[s] = den_r[s-1];
    end
  end

  // Restoring steps; quotient bits shift in as numerator bits shift out
  always_comb begin
    logic [RAW_W-1:0]      rem_v;
    logic [COORD_BITS-1:0] low_v;
    logic [RAW_W:0]        t;
    logic                  qb;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_v = rem_in[s];
      low_v = low_in[s];
      for (int k = 0; k < DIV_SPS; k++) begin
        if (s * DIV_SPS + k < COORD_BITS) begin
          t = {rem_v, low_v[COORD_BITS-1]};
          if (t >= {1'b0, den_in[s]}) begin
            t  = t - {1'b0, den_in[s]};
            qb = 1'b1;
          end else begin
            qb = 1'b0;
          end
          rem_v = t[RAW_W-1:0];
          low_v = {low_v[COORD_BITS-2:0], qb};
        end
      end
      rem_nxt[s] = rem_v;
      low_nxt[s] = low_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_r[s] <= rem_nxt[s];
      low_r[s] <= low_nxt[s];
      den_r[s] <= den_in[s];
    end
  end

  assign quot_o = low_r[DIV_STAGES-1];

endmodule

@@ design/touch_raw_to_logical_transform.sv @@
// ----------------------------------------------------------------------------
// touch_raw_to_logical_transform
// Maps a raw touch sample to rotated logical display coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_raw_x/in_raw_y with start high; the item is taken at a
//   clock edge where start is high and busy is low. busy is low except
//   while rst_n is asserted, so a new item can be taken every cycle.
//   Output: each item gives one result, shown for one cycle with
//   out_strobe high, after it has passed the front, multiply, divider
//   and output registers. There is no backpressure: the receiver
//   must take every result as it appears.
//   Pipeline: swap and window check, one multiply per axis, a per-axis
//   restoring divider of DIV_STAGES stages (DIV_SPS quotient bits each),
//   then mirror, rotation and the output register. Throughput is one
//   item per cycle while busy is low.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Change registers only while no item is in
//   flight; the pipeline reads them live.
//   Reset: synchronous rst_n clears the in-flight valid bits and loads the
//   register defaults (window 0..4095, panel size zero, so points are
//   reported invalid until the panel size is written).
// ----------------------------------------------------------------------------
module touch_raw_to_logical_transform
  import tfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // item input
  input  logic                  start,
  output logic                  busy,
  input  logic [RAW_W-1:0]      in_raw_x,
  input  logic [RAW_W-1:0]      in_raw_y,
  // result output
  output logic                  out_strobe,
  output logic                  out_point_valid,
  output logic [COORD_BITS-1:0] out_logical_x,
  output logic [COORD_BITS-1:0] out_logical_y,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [RAW_W-1:0]      raw_min_x_r, raw_max_x_r, raw_min_y_r, raw_max_y_r;
  logic [FLAG_W-1:0]     axis_flags_r;
  logic [COORD_BITS-1:0] panel_width_r, panel_height_r;
  orient_t               orientation_r;

  // Pipeline registers
  ctl_t                  ctl_r [LAT];
  logic [RAW_W-1:0]      diff_x_r, diff_y_r;
  logic [NUM_W-1:0]      num_x_r, num_y_r;
  logic                  pv_r;
  logic [COORD_BITS-1:0] lx_r, ly_r;

  logic                  accept;
  logic [RAW_W-1:0]      sx, sy;
  logic                  ok_nxt;
  logic [COORD_BITS-1:0] wm1, hm1;
  logic [RAW_W-1:0]      den_x, den_y;
  logic [NUM_W-1:0]      num_x_nxt, num_y_nxt;
  logic [COORD_BITS-1:0] qx, qy, px, py;
  logic                  pv_nxt;
  logic [COORD_BITS-1:0] lx_nxt, ly_nxt;

  assign busy      = ~rst_n;
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_min_x_r    <= '0;
      raw_max_x_r    <= RAW_W'(4095);
      raw_min_y_r    <= '0;
      raw_max_y_r    <= RAW_W'(4095);
      axis_flags_r   <= '0;
      panel_width_r  <= '0;
      panel_height_r <= '0;
      orientation_r  <= ORI_PORTRAIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RAW_MIN_X:    raw_min_x_r    <= cfg_data[RAW_W-1:0];
        CFG_RAW_MAX_X:    raw_max_x_r    <= cfg_data[RAW_W-1:0];
        CFG_RAW_MIN_Y:    raw_min_y_r    <= cfg_data[RAW_W-1:0];
        CFG_RAW_MAX_Y:    raw_max_y_r    <= cfg_data[RAW_W-1:0];
        CFG_AXIS_FLAGS:   axis_flags_r   <= cfg_data[FLAG_W-1:0];
        CFG_PANEL_WIDTH:  panel_width_r  <= cfg_data[COORD_BITS-1:0];
        CFG_PANEL_HEIGHT: panel_height_r <= cfg_data[COORD_BITS-1:0];
        CFG_ORIENTATION:  orientation_r  <= orient_t'(cfg_data[ORIENT_W-1:0]);
        default: ;
      endcase
    end
  end

  assign wm1   = panel_width_r - 1'b1;
  assign hm1   = panel_height_r - 1'b1;
  assign den_x = raw_max_x_r - raw_min_x_r;
  assign den_y = raw_max_y_r - raw_min_y_r;

  // Front stage: swap axes, check configuration and window
  always_comb begin
    sx = axis_flags_r[FLAG_SWAP] ? in_raw_y : in_raw_x;
    sy = axis_flags_r[FLAG_SWAP] ? in_raw_x : in_raw_y;
    ok_nxt = (panel_width_r != '0) && (panel_height_r != '0) &&
             (raw_max_x_r > raw_min_x_r) && (raw_max_y_r > raw_min_y_r) &&
             (sx >= raw_min_x_r) && (sx <= raw_max_x_r) &&
             (sy >= raw_min_y_r) && (sy <= raw_max_y_r);
  end

  always_ff @(posedge clk) begin
    diff_x_r <= sx - raw_min_x_r;
    diff_y_r <= sy - raw_min_y_r;
  end

  // Multiply stage: offset times (size - 1)
  assign num_x_nxt = {{COORD_BITS{1'b0}}, diff_x_r} * {{RAW_W{1'b0}}, wm1};
  assign num_y_nxt = {{COORD_BITS{1'b0}}, diff_y_r} * {{RAW_W{1'b0}}, hm1};

  always_ff @(posedge clk) begin
    num_x_r <= num_x_nxt;
    num_y_r <= num_y_nxt;
  end

  // Divider stages
  tfm_div u_div_x (.clk(clk), .num_i(num_x_r), .den_i(den_x), .quot_o(qx));
  tfm_div u_div_y (.clk(clk), .num_i(num_y_r), .den_i(den_y), .quot_o(qy));

  // Output stage: mirror, then rotate; invalid points are forced to zero
  always_comb begin
    px = axis_flags_r[FLAG_MIRROR_X] ? (wm1 - qx) : qx;
    py = axis_flags_r[FLAG_MIRROR_Y] ? (hm1 - qy) : qy;
    case (orientation_r)
      ORI_PORTRAIT: begin
        lx_nxt = hm1 - py;
        ly_nxt = px;
      end
      ORI_LANDSCAPE_CW: begin
        lx_nxt = wm1 - px;
        ly_nxt = hm1 - py;
      end
      ORI_PORTRAIT_INV: begin
        lx_nxt = py;
        ly_nxt = wm1 - px;
      end
      default: begin
        lx_nxt = px;
        ly_nxt = py;
      end
    endcase
    pv_nxt = ctl_r[LAT-2].ok;
    if (!pv_nxt) begin
      lx_nxt = '0;
      ly_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    pv_r <= pv_nxt;
    lx_r <= lx_nxt;
    ly_r <= ly_nxt;
  end

  // Control pipe: valid and in-range flag travel with the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      ctl_r[0] <= '{vld: accept, ok: ok_nxt};
      for (int i = 1; i < LAT; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  assign out_strobe      = ctl_r[LAT-1].vld;
  assign out_point_valid = pv_r;
  assign out_logical_x   = lx_r;
  assign out_logical_y   = ly_r;

  // Assertions
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_strobe)
    else $error("accepted item produced no result at fixed latency");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LAT))
    else $error("result without a matching accepted item");

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_point_valid |-> out_logical_x == '0 && out_logical_y == '0)
    else $error("invalid point with nonzero coordinates");

endmodule

@@ tb/touch_xform_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_xform_checker
// Watches the sample, result and register channels of the touch transform,
// predicts each logical point from its own copy of the calibration registers
// and compares every strobed result field by field with the oldest
// prediction still outstanding.
// ----------------------------------------------------------------------------
module touch_xform_checker
  import tfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [RAW_W-1:0]      raw_x,
  input  logic [RAW_W-1:0]      raw_y,
  input  logic                  out_strobe,
  input  logic                  point_valid,
  input  logic [COORD_BITS-1:0] logical_x,
  input  logic [COORD_BITS-1:0] logical_y,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    err_cnt,
  output int                    pending
);

  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    logic                  ok;
    logic [COORD_BITS-1:0] lx;
    logic [COORD_BITS-1:0] ly;
  } touch_pt_t;

  // Shadow of the calibration registers
  logic [RAW_W-1:0]      cal_min_x, cal_max_x, cal_min_y, cal_max_y;
  logic [FLAG_W-1:0]     flags;
  logic [COORD_BITS-1:0] pan_w, pan_h;
  orient_t               orient;

  // Points predicted for items in flight, oldest first
  touch_pt_t pt_q[$];

  initial begin
    err_cnt = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    if (err_cnt < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
    err_cnt++;
  endtask

  // (v - lo) * (size - 1) / (hi - lo), unsigned 32-bit truncating divide
  function automatic logic [COORD_BITS-1:0] scale_to_panel(
    input logic [RAW_W-1:0] v, lo, hi, input logic [COORD_BITS-1:0] size);
    logic [31:0] num, quo;
    num = (32'(v) - 32'(lo)) * (32'(size) - 32'd1);
    quo = num / (32'(hi) - 32'(lo));
    return quo[COORD_BITS-1:0];
  endfunction

  // Raw sample to rotated logical point under the current registers
  function automatic touch_pt_t map_touch_point(input logic [RAW_W-1:0] rx, ry);
    touch_pt_t             pt;
    logic [RAW_W-1:0]      sx, sy;
    logic [COORD_BITS-1:0] px, py;
    pt = '0;
    if (pan_w == 0 || pan_h == 0 || cal_max_x <= cal_min_x || cal_max_y <= cal_min_y)
      return pt;
    sx = flags[FLAG_SWAP] ? ry : rx;
    sy = flags[FLAG_SWAP] ? rx : ry;
    if (sx < cal_min_x || sx > cal_max_x || sy < cal_min_y || sy > cal_max_y)
      return pt;
    px = scale_to_panel(sx, cal_min_x, cal_max_x, pan_w);
    py = scale_to_panel(sy, cal_min_y, cal_max_y, pan_h);
    if (flags[FLAG_MIRROR_X]) px = pan_w - 1'b1 - px;
    if (flags[FLAG_MIRROR_Y]) py = pan_h - 1'b1 - py;
    pt.ok = 1'b1;
    case (orient)
      ORI_PORTRAIT: begin
        pt.lx = pan_h - 1'b1 - py;
        pt.ly = px;
      end
      ORI_LANDSCAPE_CW: begin
        pt.lx = pan_w - 1'b1 - px;
        pt.ly = pan_h - 1'b1 - py;
      end
      ORI_PORTRAIT_INV: begin
        pt.lx = py;
        pt.ly = pan_w - 1'b1 - px;
      end
      default: begin
        pt.lx = px;
        pt.ly = py;
      end
    endcase
    return pt;
  endfunction

  // Results are checked before new items are predicted; register writes land last
  always @(posedge clk) begin : monitor
    touch_pt_t want;
    if (!rst_n) begin
      cal_min_x = '0;
      cal_max_x = RAW_W'(4095);
      cal_min_y = '0;
      cal_max_y = RAW_W'(4095);
      flags     = '0;
      pan_w     = '0;
      pan_h     = '0;
      orient    = ORI_PORTRAIT;
      pt_q.delete();
    end else begin
      if (out_strobe === 1'b1) begin
        if (pt_q.size() == 0) begin
          report_mismatch("result with no item in flight", 0, 1);
        end else begin
          want = pt_q.pop_front();
          if (point_valid !== want.ok)
            report_mismatch("point_valid", int'(want.ok), int'(point_valid));
          if (logical_x !== want.lx)
            report_mismatch("logical_x", int'(want.lx), int'(logical_x));
          if (logical_y !== want.ly)
            report_mismatch("logical_y", int'(want.ly), int'(logical_y));
        end
      end
      if (start && !busy) pt_q.push_back(map_touch_point(raw_x, raw_y));
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RAW_MIN_X:    cal_min_x = cfg_data[RAW_W-1:0];
          CFG_RAW_MAX_X:    cal_max_x = cfg_data[RAW_W-1:0];
          CFG_RAW_MIN_Y:    cal_min_y = cfg_data[RAW_W-1:0];
          CFG_RAW_MAX_Y:    cal_max_y = cfg_data[RAW_W-1:0];
          CFG_AXIS_FLAGS:   flags     = cfg_data[FLAG_W-1:0];
          CFG_PANEL_WIDTH:  pan_w     = cfg_data[COORD_BITS-1:0];
          CFG_PANEL_HEIGHT: pan_h     = cfg_data[COORD_BITS-1:0];
          CFG_ORIENTATION:  orient    = orient_t'(cfg_data[ORIENT_W-1:0]);
          default: ;
        endcase
      end
    end
    pending = pt_q.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw touch samples and calibration setups into the transform: a
// directed pass over window edges, empty windows, zero panel sizes, every
// flag and orientation, then random setups with shaped samples under three
// sender idle profiles. A side checker predicts and compares the results.
// ----------------------------------------------------------------------------
module testbench;
  import tfm_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int ITEMS_PER_SETUP = 25;
  localparam int SETUPS_PER_PHASE = 6;

  localparam logic [FLAG_W-1:0] F_SWAP = FLAG_W'(1 << FLAG_SWAP);
  localparam logic [FLAG_W-1:0] F_MX   = FLAG_W'(1 << FLAG_MIRROR_X);
  localparam logic [FLAG_W-1:0] F_MY   = FLAG_W'(1 << FLAG_MIRROR_Y);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [RAW_W-1:0]      in_raw_x = '0;
  logic [RAW_W-1:0]      in_raw_y = '0;
  logic                  out_strobe;
  logic                  out_point_valid;
  logic [COORD_BITS-1:0] out_logical_x;
  logic [COORD_BITS-1:0] out_logical_y;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int err_cnt;
  int pending;
  int cycles = 0;
  int n_items = 0;
  int n_setups = 0;

  // Stimulus-side view of the active window, used to shape samples
  logic [RAW_W-1:0] st_min_x, st_max_x, st_min_y, st_max_y;
  logic [FLAG_W-1:0] st_flags;

  touch_raw_to_logical_transform DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_raw_x        (in_raw_x),
    .in_raw_y        (in_raw_y),
    .out_strobe      (out_strobe),
    .out_point_valid (out_point_valid),
    .out_logical_x   (out_logical_x),
    .out_logical_y   (out_logical_y),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  touch_xform_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .raw_x       (in_raw_x),
    .raw_y       (in_raw_y),
    .out_strobe  (out_strobe),
    .point_valid (out_point_valid),
    .logical_x   (out_logical_x),
    .logical_y   (out_logical_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .err_cnt     (err_cnt),
    .pending     (pending)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stop sending and let every point in flight come out
  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LAT + 2) @(negedge clk);
  endtask

  // One register write; leaves cfg_valid high for a following write
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Full register setup while idle; narrow registers get junk upper bits
  task automatic set_cfg(input logic [RAW_W-1:0] min_x, max_x, min_y, max_y,
                         input logic [FLAG_W-1:0] fl,
                         input logic [COORD_BITS-1:0] w, h, input orient_t ori);
    logic [CFG_DATA_W-1:0] junk;
    drain();
    st_min_x = min_x;
    st_max_x = max_x;
    st_min_y = min_y;
    st_max_y = max_y;
    st_flags = fl;
    write_reg(CFG_RAW_MIN_X, min_x);
    write_reg(CFG_RAW_MAX_X, max_x);
    write_reg(CFG_RAW_MIN_Y, min_y);
    write_reg(CFG_RAW_MAX_Y, max_y);
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_AXIS_FLAGS, {junk[CFG_DATA_W-1:FLAG_W], fl});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_PANEL_WIDTH, {junk[CFG_DATA_W-1:COORD_BITS], w});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_PANEL_HEIGHT, {junk[CFG_DATA_W-1:COORD_BITS], h});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_ORIENTATION, {junk[CFG_DATA_W-1:ORIENT_W], ori});
    cfg_valid = 1'b0;
    n_setups++;
  endtask

  // One sample, with random idle cycles ahead of it
  task automatic send_item(input logic [RAW_W-1:0] x, y, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start    = 1'b1;
    in_raw_x = x;
    in_raw_y = y;
    do @(posedge clk); while (busy);
    @(negedge clk);
    n_items++;
  endtask

  task automatic pick_window(output logic [RAW_W-1:0] lo, hi);
    case ($urandom_range(15))
      0: begin
        lo = RAW_W'($urandom);
        hi = lo;
      end
      1: begin
        hi = RAW_W'($urandom_range(65534));
        lo = RAW_W'($urandom_range(65535, hi + 1));
      end
      2: begin
        lo = '0;
        hi = '1;
      end
      3: begin
        lo = RAW_W'($urandom_range(65519));
        hi = RAW_W'(lo + $urandom_range(16, 1));
      end
      default: begin
        lo = RAW_W'($urandom_range(30000));
        hi = RAW_W'(lo + $urandom_range(35535, 1));
      end
    endcase
  endtask

  function automatic logic [COORD_BITS-1:0] pick_size();
    case ($urandom_range(19))
      0:       return '0;
      1, 2:    return COORD_BITS'(1);
      3, 4:    return '1;
      default: return COORD_BITS'($urandom_range((1 << COORD_BITS) - 1, 1));
    endcase
  endfunction

  // Mostly inside the window, with edges, just-outside and full-range noise
  function automatic logic [RAW_W-1:0] pick_axis(input logic [RAW_W-1:0] lo, hi);
    case ($urandom_range(11))
      0:       return RAW_W'($urandom);
      1:       return lo;
      2:       return hi;
      3:       return lo - 1'b1;
      4:       return hi + 1'b1;
      default: return (hi >= lo) ? RAW_W'($urandom_range(hi, lo)) : RAW_W'($urandom);
    endcase
  endfunction

  task automatic random_setup();
    logic [RAW_W-1:0]    lo_x, hi_x, lo_y, hi_y;
    logic [FLAG_W-1:0]   fl;
    logic [ORIENT_W-1:0] ori_bits;
    pick_window(lo_x, hi_x);
    pick_window(lo_y, hi_y);
    fl = FLAG_W'($urandom_range(7));
    ori_bits = ORIENT_W'($urandom_range(3));
    set_cfg(lo_x, hi_x, lo_y, hi_y, fl, pick_size(), pick_size(), orient_t'(ori_bits));
  endtask

  // Source axes are picked against the window, then swapped back to raw order
  task automatic random_item(input int idle_pct);
    logic [RAW_W-1:0] sx, sy;
    sx = pick_axis(st_min_x, st_max_x);
    sy = pick_axis(st_min_y, st_max_y);
    if (st_flags[FLAG_SWAP]) send_item(sy, sx, idle_pct);
    else send_item(sx, sy, idle_pct);
  endtask

  initial begin
    int idle_prof[3];
    idle_prof = '{25, 46, 0};

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset registers: zero panel size, point must be invalid
    send_item(16'd100, 16'd100, 0);

    // Full raw range, largest panel, corners and alternating bits
    set_cfg(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, '0, 12'd4095, 12'd4095, ORI_PORTRAIT);
    send_item(16'h0000, 16'h0000, 0);
    send_item(16'hFFFF, 16'hFFFF, 0);
    send_item(16'h0000, 16'hFFFF, 0);
    send_item(16'hFFFF, 16'h0000, 0);
    send_item(16'hAAAA, 16'h5555, 0);

    // Swap plus mirror x, landscape cw
    set_cfg(16'd0, 16'd4095, 16'd0, 16'd4095, F_SWAP | F_MX, 12'd4095, 12'd2000,
            ORI_LANDSCAPE_CW);
    send_item(16'd4095, 16'd0, 0);
    send_item(16'd0, 16'd4095, 0);
    send_item(16'd1234, 16'd3000, 0);

    // Narrow window, one-pixel panel: window edges and just outside them
    set_cfg(16'd100, 16'd200, 16'd300, 16'd400, F_MY, 12'd1, 12'd1, ORI_PORTRAIT_INV);
    send_item(16'd99, 16'd300, 0);
    send_item(16'd201, 16'd300, 0);
    send_item(16'd100, 16'd299, 0);
    send_item(16'd200, 16'd401, 0);
    send_item(16'd150, 16'd350, 0);
    send_item(16'd100, 16'd300, 0);
    send_item(16'd200, 16'd400, 0);

    // Empty window on x (max equals min)
    set_cfg(16'd500, 16'd500, 16'd0, 16'd4095, '0, 12'd640, 12'd480, ORI_LANDSCAPE_CCW);
    send_item(16'd500, 16'd10, 0);

    // Reversed window on y
    set_cfg(16'd0, 16'd4095, 16'd3000, 16'd2000, F_MX, 12'd640, 12'd480, ORI_PORTRAIT);
    send_item(16'd10, 16'd2500, 0);

    // Zero panel height only
    set_cfg(16'd0, 16'd4095, 16'd0, 16'd4095, F_SWAP | F_MX | F_MY, 12'd800, 12'd0,
            ORI_LANDSCAPE_CW);
    send_item(16'd1000, 16'd1000, 0);

    // Smallest nonempty window against the widest one, all flags
    set_cfg(16'd0, 16'd1, 16'd0, 16'hFFFF, F_SWAP | F_MX | F_MY, 12'd4095, 12'd4095,
            ORI_LANDSCAPE_CCW);
    send_item(16'hFFFF, 16'd1, 0);
    send_item(16'd0, 16'd0, 0);

    // Random setups under each sender idle profile
    foreach (idle_prof[p]) begin
      repeat (SETUPS_PER_PHASE) begin
        random_setup();
        repeat (ITEMS_PER_SETUP) random_item(idle_prof[p]);
      end
    end

    drain();
    $display("Covered %0d samples over %0d register setups: window edges, empty windows,",
             n_items, n_setups);
    $display("zero and one-pixel panels, swap/mirror flags, all orientations,");
    $display("idle gaps and back-to-back items.");
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
